### rtl/free_list_block_allocator_macros.svh
// Assertion macros for the free list block allocator checker.
// Clocked on clk, disabled while rst_n is low; no other dependencies.
`ifndef FREE_LIST_BLOCK_ALLOCATOR_MACROS_SVH
`define FREE_LIST_BLOCK_ALLOCATOR_MACROS_SVH

// Same-cycle implication.
`define FLA_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define FLA_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/fla_pkg.sv
// Shared types and constants for the free list block allocator.
// No dependencies.
package fla_pkg;

    localparam int MAX_BLOCKS = 1024;
    localparam int IDX_W      = $clog2(MAX_BLOCKS);
    localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);

    localparam logic [CNT_W-1:0] LINK_END = CNT_W'(MAX_BLOCKS);

    localparam int S_TDATA_W = ((IDX_W + 7) / 8) * 8;
    localparam int M_TUSER_W = 3;
    localparam int M_TDATA_W = ((IDX_W + CNT_W + 7) / 8) * 8;

    // request codes
    localparam logic [1:0] REQ_INIT  = 2'd0;
    localparam logic [1:0] REQ_ALLOC = 2'd1;
    localparam logic [1:0] REQ_FREE  = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EMPTY     = 2'd1;
    localparam logic [1:0] ST_RANGE     = 2'd2;
    localparam logic [1:0] ST_NOT_ALLOC = 2'd3;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_WALK,
        S_INIT_DONE
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic accept;      // capture request, issue memory read
        logic clear_step;  // reset sweep: clear one allocated bit
        logic walk_step;   // init walk: link one block
        logic exec_commit; // finish allocate / free / no-op
        logic init_commit; // finish init
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic walk_last;
        logic out_free;
    } stat_t;

endpackage

### rtl/fla_ctrl.sv
// Controller FSM for the free list block allocator.
// Depends on fla_pkg.
module fla_ctrl
    import fla_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [1:0] in_req,
    output logic       in_ready,
    input  stat_t      stat,
    output cmd_t       cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (stat.walk_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = (in_req == REQ_INIT) ? S_WALK : S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (stat.out_free)
                begin
                    cmd.exec_commit = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_WALK:
            begin
                cmd.walk_step = 1'b1;
                if (stat.walk_last)
                begin
                    state_next = S_INIT_DONE;
                end
            end
            S_INIT_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.init_commit = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

endmodule

### rtl/fla_datapath.sv
// Datapath: link and allocated-bit stores, head/count registers, result register.
// Depends on fla_pkg; driven by fla_ctrl commands.
module fla_datapath
    import fla_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CNT_W-1:0] cfg_wdata,
    input  logic [1:0]       in_req,
    input  logic [IDX_W-1:0] in_fidx,
    input  cmd_t             cmd,
    output stat_t            stat,
    input  logic             out_ready,
    output logic             out_valid,
    output logic             out_granted,
    output logic [IDX_W-1:0] out_bidx,
    output logic [1:0]       out_status,
    output logic [CNT_W-1:0] out_free_blocks
);

    logic [CNT_W-1:0] link_data [MAX_BLOCKS];
    logic             alloc_mem [MAX_BLOCKS];

    logic [CNT_W-1:0] bcount_reg;
    logic [CNT_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0] total_reg, total_next;
    logic [CNT_W-1:0] active_reg;
    logic [CNT_W-1:0] n_reg;
    logic [IDX_W-1:0] walk_reg;
    logic [1:0]       req_reg;
    logic [IDX_W-1:0] fidx_reg;
    logic [CNT_W-1:0] link_rd_reg;
    logic             alloc_rd_reg;

    logic             out_valid_reg;
    logic             granted_reg;
    logic [IDX_W-1:0] bidx_reg;
    logic [1:0]       status_reg;
    logic [CNT_W-1:0] free_reg;

    logic [CNT_W-1:0] n_clamped;
    logic [IDX_W-1:0] rd_addr;
    logic             walk_last;
    logic             alloc_ok, free_range, free_ok;
    logic [1:0]       exec_status;

    logic             link_we;
    logic [IDX_W-1:0] link_wa;
    logic [CNT_W-1:0] link_wd;
    logic             alloc_we;
    logic [IDX_W-1:0] alloc_wa;
    logic             alloc_wd;

    always_comb
    begin
        if (bcount_reg == '0)
        begin
            n_clamped = CNT_W'(1);
        end
        else if (bcount_reg > LINK_END)
        begin
            n_clamped = LINK_END;
        end
        else
        begin
            n_clamped = bcount_reg;
        end
    end

    assign rd_addr   = (in_req == REQ_ALLOC) ? head_reg[IDX_W-1:0] : in_fidx;
    assign walk_last = ({1'b0, walk_reg} == (n_reg - CNT_W'(1)));

    // request decode, from captured request and read data
    assign alloc_ok   = (req_reg == REQ_ALLOC) && (total_reg != '0) && !head_reg[CNT_W-1];
    assign free_range = (req_reg == REQ_FREE) && ({1'b0, fidx_reg} >= active_reg);
    assign free_ok    = (req_reg == REQ_FREE) && !free_range && alloc_rd_reg;

    always_comb
    begin
        exec_status = ST_OK;
        head_next   = head_reg;
        total_next  = total_reg;
        case (req_reg)
            REQ_ALLOC:
            begin
                if (alloc_ok)
                begin
                    head_next  = (link_rd_reg > LINK_END) ? LINK_END : link_rd_reg;
                    total_next = total_reg - CNT_W'(1);
                end
                else
                begin
                    exec_status = ST_EMPTY;
                end
            end
            REQ_FREE:
            begin
                if (free_range)
                begin
                    exec_status = ST_RANGE;
                end
                else if (!alloc_rd_reg)
                begin
                    exec_status = ST_NOT_ALLOC;
                end
                else
                begin
                    head_next  = {1'b0, fidx_reg};
                    total_next = total_reg + CNT_W'(1);
                end
            end
            default:
            begin
                exec_status = ST_OK;
            end
        endcase
    end

    // memory write port selection
    always_comb
    begin
        link_we  = 1'b0;
        link_wa  = walk_reg;
        link_wd  = LINK_END;
        alloc_we = 1'b0;
        alloc_wa = walk_reg;
        alloc_wd = 1'b0;
        if (cmd.clear_step)
        begin
            alloc_we = 1'b1;
        end
        else if (cmd.walk_step)
        begin
            link_we  = 1'b1;
            link_wd  = walk_last ? LINK_END : ({1'b0, walk_reg} + CNT_W'(1));
            alloc_we = 1'b1;
        end
        else if (cmd.exec_commit && alloc_ok)
        begin
            link_we  = 1'b1;
            link_wa  = head_reg[IDX_W-1:0];
            link_wd  = LINK_END;
            alloc_we = 1'b1;
            alloc_wa = head_reg[IDX_W-1:0];
            alloc_wd = 1'b1;
        end
        else if (cmd.exec_commit && free_ok)
        begin
            link_we  = 1'b1;
            link_wa  = fidx_reg;
            link_wd  = head_reg;
            alloc_we = 1'b1;
            alloc_wa = fidx_reg;
            alloc_wd = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_data[link_wa] <= link_wd;
        end
        if (cmd.accept)
        begin
            link_rd_reg <= link_data[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (alloc_we)
        begin
            alloc_mem[alloc_wa] <= alloc_wd;
        end
        if (cmd.accept)
        begin
            alloc_rd_reg <= alloc_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            req_reg  <= in_req;
            fidx_reg <= in_fidx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bcount_reg    <= LINK_END;
            head_reg      <= '0;
            total_reg     <= LINK_END;
            active_reg    <= LINK_END;
            n_reg         <= LINK_END;
            walk_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                bcount_reg <= cfg_wdata;
            end
            if (cmd.accept && (in_req == REQ_INIT))
            begin
                n_reg    <= n_clamped;
                walk_reg <= '0;
            end
            else if (cmd.clear_step || cmd.walk_step)
            begin
                walk_reg <= walk_reg + IDX_W'(1);
            end
            if (cmd.exec_commit)
            begin
                head_reg  <= head_next;
                total_reg <= total_next;
            end
            else if (cmd.init_commit)
            begin
                head_reg   <= '0;
                total_reg  <= n_reg;
                active_reg <= n_reg;
            end
            if (cmd.exec_commit || cmd.init_commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec_commit)
        begin
            granted_reg <= alloc_ok;
            bidx_reg    <= alloc_ok ? head_reg[IDX_W-1:0] : '0;
            status_reg  <= exec_status;
            free_reg    <= total_next;
        end
        else if (cmd.init_commit)
        begin
            granted_reg <= 1'b0;
            bidx_reg    <= '0;
            status_reg  <= ST_OK;
            free_reg    <= n_reg;
        end
    end

    assign stat.walk_last = walk_last;
    assign stat.out_free  = !out_valid_reg || out_ready;

    assign out_valid       = out_valid_reg;
    assign out_granted     = granted_reg;
    assign out_bidx        = bidx_reg;
    assign out_status      = status_reg;
    assign out_free_blocks = free_reg;

endmodule

### rtl/free_list_block_allocator.sv
// Top level of the free list block allocator: controller plus datapath.
// Depends on fla_pkg, fla_ctrl and fla_datapath.
//
// Usage
//   Slave stream: one word per request. s_tuser = req_type (0 init, 1 allocate,
//   2 free, 3 no-op); s_tdata carries free_index, used by free only.
//   Master stream: one word per request, in request order. m_tuser holds
//   granted and status; m_tdata holds block_index and free_blocks.
//   cfg_we/cfg_wdata write block_count; it takes effect at the next init.
// Operation
//   Allocate, free, no-op: the word is taken in idle and the link and
//   allocated-bit stores are read synchronously; the result is registered
//   with the write-back once the output register is free.
//   Init: the walk links n blocks, n being the clamped block count (1..1024);
//   it writes one link per cycle through the single write port.
// Reset
//   rst_n clears head and the output valid flag, sets the counts to 1024,
//   then a sweep clears the 1024 allocated bits; s_tready stays low meanwhile.
//   Allocate before the first init reads unwritten links and is not allowed.
// Back-pressure
//   A new word is taken while a result waits; the finished result then holds
//   in the controller until m_tready frees the output register.
module free_list_block_allocator
    import fla_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CNT_W-1:0]     cfg_wdata,   // block_count
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,     // [9:0] free_index, rest zero
    input  logic [1:0]           s_tuser,     // [1:0] req_type
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,     // [9:0] block_index, [20:10] free_blocks
    output logic [M_TUSER_W-1:0] m_tuser      // [0] granted, [2:1] status
);

    cmd_t             cmd;
    stat_t            stat;
    logic             granted;
    logic [IDX_W-1:0] block_index;
    logic [1:0]       status;
    logic [CNT_W-1:0] free_blocks;

    fla_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_req   (s_tuser),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    fla_datapath u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .in_req          (s_tuser),
        .in_fidx         (s_tdata[IDX_W-1:0]),
        .cmd             (cmd),
        .stat            (stat),
        .out_ready       (m_tready),
        .out_valid       (m_tvalid),
        .out_granted     (granted),
        .out_bidx        (block_index),
        .out_status      (status),
        .out_free_blocks (free_blocks)
    );

    // pad to whole bytes
    assign m_tdata = {{(M_TDATA_W - IDX_W - CNT_W){1'b0}}, free_blocks, block_index};
    assign m_tuser = {status, granted};

endmodule

### rtl/fla_checker.sv
// Port-level checks for the free list block allocator, bound to the top level.
// Depends on fla_pkg and free_list_block_allocator_macros.svh.
`include "free_list_block_allocator_macros.svh"

module fla_checker
    import fla_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [M_TUSER_W-1:0] m_tuser
);

    `FLA_ASSERT_IMP(a_grant_ok, m_tvalid && m_tuser[0], m_tuser[2:1] == ST_OK, "grant with bad status")
    `FLA_ASSERT_IMP(a_nogrant_zero, m_tvalid && !m_tuser[0], m_tdata[IDX_W-1:0] == '0, "index without grant")
    `FLA_ASSERT_IMP(a_free_bound, m_tvalid, m_tdata[IDX_W+CNT_W-1:IDX_W] <= LINK_END, "free count too big")
    `FLA_ASSERT_NXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready, "request taken while busy")
    `FLA_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

endmodule

bind free_list_block_allocator fla_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

### tb/sv/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for free_list_block_allocator: directed table, then random phases.
// Depends on fla_pkg and the allocator RTL only; predicts each untyped report from its own pool copy.
module testbench;
    import fla_pkg::*;

    // Request type with no action; the package names only the three real ones.
    localparam logic [1:0] REQ_NOP = 2'd3;

    // One report word as seen on the master side.
    typedef struct packed {
        logic             granted;
        logic [IDX_W-1:0] block_index;
        logic [1:0]       status;
        logic [CNT_W-1:0] free_blocks;
    } report_t;

    // One row of the directed table: either a block_count write or a request word.
    typedef struct packed {
        bit               is_cfg;
        logic [CNT_W-1:0] cfg_val;
        logic [1:0]       req;
        logic [IDX_W-1:0] idx;
        bit               typed;   // report typed in below, not taken from the pool copy
        report_t          want;
    } step_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CNT_W-1:0]     cfg_wdata = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;     // [9:0] free_index, rest zero
    logic [1:0]           s_tuser = '0;     // [1:0] req_type
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;          // [9:0] block_index, [20:10] free_blocks
    logic [M_TUSER_W-1:0] m_tuser;          // [0] granted, [2:1] status

    // Own copy of the pool: links, taken bits, head, free count, active size, register.
    logic [CNT_W-1:0] pool_link [MAX_BLOCKS];
    bit               pool_taken [MAX_BLOCKS];
    logic [CNT_W-1:0] pool_head = '0;
    int               pool_free = 1024;
    int               pool_size = 1024;
    logic [CNT_W-1:0] count_reg = 11'd1024;

    report_t due_reports [$];   // reports owed by the block, oldest first
    step_t   plan [$];
    int      mismatches = 0;
    bit      calm = 1'b0;       // no idling on either side while set

    free_list_block_allocator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Applies one request to the pool copy and returns the report it should give.
    function automatic report_t apply_to_pool(input logic [1:0] req, input logic [IDX_W-1:0] idx);
        report_t          r;
        int               n;
        logic [CNT_W-1:0] nxt;
        r = '0;
        r.status = ST_OK;
        case (req)
            REQ_INIT:
            begin
                n = count_reg;
                if (n < 1) n = 1;
                if (n > MAX_BLOCKS) n = MAX_BLOCKS;
                for (int i = 0; i < n - 1; i++) pool_link[i] = CNT_W'(i + 1);
                pool_link[n-1] = LINK_END;
                for (int i = 0; i < MAX_BLOCKS; i++) pool_taken[i] = 1'b0;
                pool_head = '0;
                pool_free = n;
                pool_size = n;
            end
            REQ_ALLOC:
            begin
                if (pool_free == 0 || pool_head >= MAX_BLOCKS)
                begin
                    r.status = ST_EMPTY;
                end
                else
                begin
                    r.granted     = 1'b1;
                    r.block_index = pool_head[IDX_W-1:0];
                    nxt = pool_link[pool_head];
                    pool_link[pool_head]  = LINK_END;
                    pool_taken[pool_head] = 1'b1;
                    pool_head = (nxt > LINK_END) ? LINK_END : nxt;
                    pool_free--;
                end
            end
            REQ_FREE:
            begin
                if (idx >= pool_size)
                begin
                    r.status = ST_RANGE;
                end
                else if (!pool_taken[idx])
                begin
                    r.status = ST_NOT_ALLOC;
                end
                else
                begin
                    pool_link[idx]  = pool_head;
                    pool_head       = CNT_W'(idx);
                    pool_taken[idx] = 1'b0;
                    pool_free++;
                end
            end
            default: ;
        endcase
        r.free_blocks = CNT_W'(pool_free);
        return r;
    endfunction

    // Some block currently handed out, from a random starting point; -1 if none.
    function automatic int held_block();
        int start;
        int j;
        start = $urandom_range(0, pool_size - 1);
        for (int k = 0; k < pool_size; k++)
        begin
            j = (start + k) % pool_size;
            if (pool_taken[j]) return j;
        end
        return -1;
    endfunction

    // Called just after a rising edge; returns at the edge that takes the word.
    task automatic send_word(input logic [1:0] req, input logic [IDX_W-1:0] idx,
                             input bit typed, input report_t want);
        int      gap;
        report_t got;
        gap = calm ? 0 : $urandom_range(0, 11);
        @(negedge clk);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= S_TDATA_W'(idx);
        do @(posedge clk); while (!s_tready);
        got = apply_to_pool(req, idx);
        due_reports.push_back(typed ? want : got);
    endtask

    // block_count is only touched once every owed report is back.
    task automatic set_block_count(input logic [CNT_W-1:0] v);
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (due_reports.size() != 0) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        count_reg = v;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic cfg_row(input logic [CNT_W-1:0] v);
        step_t s;
        s = '0;
        s.is_cfg  = 1'b1;
        s.cfg_val = v;
        plan.push_back(s);
    endtask

    task automatic row(input logic [1:0] req, input logic [IDX_W-1:0] idx);
        step_t s;
        s = '0;
        s.req = req;
        s.idx = idx;
        plan.push_back(s);
    endtask

    task automatic row_is(input logic [1:0] req, input logic [IDX_W-1:0] idx, input logic g,
                          input logic [IDX_W-1:0] b, input logic [1:0] st,
                          input logic [CNT_W-1:0] f);
        step_t s;
        s = '0;
        s.req   = req;
        s.idx   = idx;
        s.typed = 1'b1;
        s.want  = '{granted: g, block_index: b, status: st, free_blocks: f};
        plan.push_back(s);
    endtask

    task automatic check_field(input string what, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $display("%0t ns: %s expected %0d, got %0d", $time, what, want, got);
            mismatches++;
        end
    endtask

    // Report side: random back-pressure, one word checked per handshake.
    initial
    begin : report_side
        int      gap;
        report_t want;
        forever
        begin
            @(negedge clk);
            gap = calm ? 0 : $urandom_range(0, 11);
            if (gap != 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            if (due_reports.size() == 0)
            begin
                $display("%0t ns: unexpected report, tdata %h tuser %h", $time, m_tdata, m_tuser);
                mismatches++;
            end
            else
            begin
                want = due_reports.pop_front();
                check_field("granted", want.granted, m_tuser[0]);
                check_field("block_index", want.block_index, m_tdata[IDX_W-1:0]);
                check_field("status", want.status, m_tuser[2:1]);
                check_field("free_blocks", want.free_blocks, m_tdata[IDX_W+CNT_W-1:IDX_W]);
            end
        end
    end

    // Request side: directed table, then phases of random traffic.
    initial
    begin : request_side
        logic [CNT_W-1:0] cnt;
        logic [IDX_W-1:0] idx;
        logic [1:0]       req;
        int               r;
        int               b;
        int               alloc_w;
        int               init_w;

        for (int i = 0; i < MAX_BLOCKS; i++) pool_link[i] = '0;

        // Before any init only free and no-op are legal: the links are still unwritten.
        row_is(REQ_FREE,  10'd5,    1'b0, 10'd0, ST_NOT_ALLOC, 11'd1024);
        row_is(REQ_NOP,   10'd1023, 1'b0, 10'd0, ST_OK,        11'd1024);
        row_is(REQ_INIT,  10'd0,    1'b0, 10'd0, ST_OK,        11'd1024);
        row_is(REQ_ALLOC, 10'd0,    1'b1, 10'd0, ST_OK,        11'd1023);
        row_is(REQ_ALLOC, 10'd1023, 1'b1, 10'd1, ST_OK,        11'd1022);
        row_is(REQ_FREE,  10'd1023, 1'b0, 10'd0, ST_NOT_ALLOC, 11'd1022);
        row_is(REQ_FREE,  10'd0,    1'b0, 10'd0, ST_OK,        11'd1023);
        row(REQ_ALLOC, 10'd0);
        // zero block count clamps to one block
        cfg_row(11'd0);
        row_is(REQ_INIT,  10'd0,    1'b0, 10'd0, ST_OK,        11'd1);
        row_is(REQ_ALLOC, 10'd0,    1'b1, 10'd0, ST_OK,        11'd0);
        row_is(REQ_ALLOC, 10'd0,    1'b0, 10'd0, ST_EMPTY,     11'd0);
        row_is(REQ_FREE,  10'd1,    1'b0, 10'd0, ST_RANGE,     11'd0);
        row_is(REQ_FREE,  10'd1023, 1'b0, 10'd0, ST_RANGE,     11'd0);
        row_is(REQ_FREE,  10'd0,    1'b0, 10'd0, ST_OK,        11'd1);
        row_is(REQ_FREE,  10'd0,    1'b0, 10'd0, ST_NOT_ALLOC, 11'd1);
        // oversize count clamps to the full pool
        cfg_row(11'd2047);
        row_is(REQ_INIT,  10'd1023, 1'b0, 10'd0, ST_OK,        11'd1024);
        row_is(REQ_FREE,  10'd682,  1'b0, 10'd0, ST_NOT_ALLOC, 11'd1024);
        cfg_row(11'd3);
        row_is(REQ_INIT,  10'd341,  1'b0, 10'd0, ST_OK,        11'd3);
        row(REQ_ALLOC, 10'd0);
        row(REQ_ALLOC, 10'd0);
        row(REQ_ALLOC, 10'd0);
        row(REQ_ALLOC, 10'd0);
        row(REQ_FREE, 10'd1);
        row(REQ_FREE, 10'd2);
        row(REQ_ALLOC, 10'd0);

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
                set_block_count(plan[i].cfg_val);
            else
                send_word(plan[i].req, plan[i].idx, plan[i].typed, plan[i].want);
        end

        // Each phase: new block_count, an init, then a well-formed mix of
        // allocates and frees of held blocks with some re-inits, stray frees and no-ops.
        for (int p = 0; p < 16; p++)
        begin
            case (p)
                0:       cnt = 11'd2047;
                1:       cnt = 11'd1;
                2:       cnt = 11'd2;
                3:       cnt = 11'd1024;
                4:       cnt = 11'd0;
                default: cnt = (p % 5 == 0) ? CNT_W'($urandom_range(49, 2047))
                                            : CNT_W'($urandom_range(1, 48));
            endcase
            calm    = (p % 4 == 3);
            alloc_w = $urandom_range(350, 600);
            init_w  = (cnt <= 64) ? 20 : 3;   // a re-init walks the whole pool
            set_block_count(cnt);
            send_word(REQ_INIT, IDX_W'($urandom_range(0, 1023)), 1'b0, '0);
            for (int k = 0; k < 119; k++)
            begin
                r   = $urandom_range(0, 999);
                idx = IDX_W'($urandom_range(0, 1023));
                if (r < init_w)
                begin
                    req = REQ_INIT;
                end
                else if (r < init_w + alloc_w)
                begin
                    req = REQ_ALLOC;
                end
                else if (r < 900)
                begin
                    req = REQ_FREE;
                    b = held_block();
                    if (b >= 0) idx = IDX_W'(b);
                end
                else if (r < 960)
                begin
                    // stray free: either anywhere or just past the active pool
                    req = REQ_FREE;
                    if (r < 930)
                    begin
                        b = pool_size + $urandom_range(0, 3);
                        if (b <= 1023) idx = IDX_W'(b);
                    end
                end
                else
                begin
                    req = REQ_NOP;
                end
                send_word(req, idx, 1'b0, '0);
            end
        end

        @(negedge clk);
        s_tvalid <= 1'b0;
        calm = 1'b0;
        while (due_reports.size() != 0) @(negedge clk);
        repeat (8) @(negedge clk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run (stalls, full-pool walks, reset sweep).
    initial
    begin : watchdog
        #4000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
